FILE: sv/fbs_pkg.sv
// fbs_pkg: shared types and constants for the fan boost safeguard.
// Holds controller states, controller/datapath command and status structs, timing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbs_pkg;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_GATE,
        S_FILT,
        S_EVAL,
        S_DIV_T_LOAD,
        S_DIV_T,
        S_DIV_H_LOAD,
        S_DIV_H,
        S_DECIDE,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic gate;
        logic filt;
        logic eval;
        logic div_load;
        logic div_sel;
        logic div_step;
        logic decide;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic done;
        logic emit;
        logic div_last;
        logic out_free;
    } t_dp_stat;

    // result kinds
    localparam logic KIND_BOOST   = 1'b0;
    localparam logic KIND_RESTORE = 1'b1;

    // divider selects
    localparam logic SEL_TEMP = 1'b0;
    localparam logic SEL_HUM  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_GUARD_ENABLE = 2'd0;
    localparam logic [1:0] REG_TEMP_LIMIT   = 2'd1;
    localparam logic [1:0] REG_HUM_LIMIT    = 2'd2;

    // register reset values
    localparam logic       GUARD_ENABLE_RST = 1'b0;
    localparam logic [7:0] TEMP_LIMIT_RST   = 8'd60;
    localparam logic [6:0] HUM_LIMIT_RST    = 7'd80;

    // timing in milliseconds
    localparam logic [31:0] TICK_GAP_MS = 32'd2000;
    localparam logic [31:0] ACTIVATE_MS = 32'd30000;
    localparam logic [31:0] CLEAR_MS    = 32'd90000;
    localparam logic [31:0] INVALID_MS  = 32'd60000;
    localparam logic [31:0] CMD_GAP_MS  = 32'd15000;

    // speed shaping
    localparam logic [7:0] BOOST_OFFSET = 8'd20;
    localparam logic [7:0] RAMP_STEP    = 8'd10;
    localparam logic [7:0] SPEED_MAX    = 8'd100;

    // hysteresis floors (clear margin times 20)
    localparam logic [15:0] TEMP_CLR_FLOOR = 16'd60;
    localparam logic [15:0] HUM_CLR_FLOOR  = 16'd100;

    // quotient bits of the severity divider
    localparam int unsigned DIV_BITS = 7;

endpackage

`default_nettype wire

FILE: sv/fbs_ctrl.sv
// fbs_ctrl: sequencer for the fan boost safeguard.
// Steps each tick through gate, filter, evaluate, divide, decide and emit; gate or evaluate can end it early.
// Depends on fbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbs_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  fbs_pkg::t_dp_stat i_stat,
    output fbs_pkg::t_dp_cmd  o_cmd
);

    fbs_pkg::t_state r_state;
    fbs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbs_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fbs_pkg::S_GATE;
            end
            fbs_pkg::S_GATE: begin
                if (i_stat.done) begin
                    n_state = i_stat.emit ? fbs_pkg::S_EMIT : fbs_pkg::S_IDLE;
                end else begin
                    n_state = fbs_pkg::S_FILT;
                end
            end
            fbs_pkg::S_FILT: n_state = fbs_pkg::S_EVAL;
            fbs_pkg::S_EVAL: begin
                if (i_stat.done) begin
                    n_state = i_stat.emit ? fbs_pkg::S_EMIT : fbs_pkg::S_IDLE;
                end else begin
                    n_state = fbs_pkg::S_DIV_T_LOAD;
                end
            end
            fbs_pkg::S_DIV_T_LOAD: n_state = fbs_pkg::S_DIV_T;
            fbs_pkg::S_DIV_T: begin
                if (i_stat.div_last) n_state = fbs_pkg::S_DIV_H_LOAD;
            end
            fbs_pkg::S_DIV_H_LOAD: n_state = fbs_pkg::S_DIV_H;
            fbs_pkg::S_DIV_H: begin
                if (i_stat.div_last) n_state = fbs_pkg::S_DECIDE;
            end
            fbs_pkg::S_DECIDE: begin
                n_state = i_stat.emit ? fbs_pkg::S_EMIT : fbs_pkg::S_IDLE;
            end
            fbs_pkg::S_EMIT: begin
                if (i_stat.out_free) n_state = fbs_pkg::S_IDLE;
            end
            default: n_state = fbs_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            fbs_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            fbs_pkg::S_GATE:   o_cmd.gate = 1'b1;
            fbs_pkg::S_FILT:   o_cmd.filt = 1'b1;
            fbs_pkg::S_EVAL:   o_cmd.eval = 1'b1;
            fbs_pkg::S_DIV_T_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = fbs_pkg::SEL_TEMP;
            end
            fbs_pkg::S_DIV_T:  o_cmd.div_step = 1'b1;
            fbs_pkg::S_DIV_H_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = fbs_pkg::SEL_HUM;
            end
            fbs_pkg::S_DIV_H:  o_cmd.div_step = 1'b1;
            fbs_pkg::S_DECIDE: o_cmd.decide = 1'b1;
            fbs_pkg::S_EMIT:   o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    // at most one datapath phase at a time
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.gate, o_cmd.filt, o_cmd.eval, o_cmd.div_load,
                  o_cmd.div_step, o_cmd.decide, o_cmd.out_load}))
        else $error("fbs_ctrl: overlapping datapath phases");

    // an accepted transaction enters the gate phase
    a_accept_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == fbs_pkg::S_GATE))
        else $error("fbs_ctrl: accepted transaction not gated");

    // a pending result waits while the output slot is full
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbs_pkg::S_EMIT && !i_stat.out_free) |=> (r_state == fbs_pkg::S_EMIT))
        else $error("fbs_ctrl: pending result dropped");
`endif

endmodule

`default_nettype wire

FILE: sv/fbs_dp.sv
// fbs_dp: datapath of the fan boost safeguard.
// Holds filters, timers, learned base speed, severity divider and the output slot.
// Depends on fbs_pkg; driven by fbs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fbs_dp #(
    parameter int unsigned SAMPLE_FRAC_BITS = 6
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  fbs_pkg::t_dp_cmd   i_cmd,
    output fbs_pkg::t_dp_stat  o_stat,
    input  wire                i_guard_enable,
    input  wire  [7:0]         i_temp_limit,
    input  wire  [6:0]         i_hum_limit,
    input  wire  [31:0]        i_now_ms,
    input  wire                i_fan_valid,
    input  wire  [6:0]         i_fan_speed,
    input  wire                i_fan_on,
    input  wire                i_temp_ok,
    input  wire signed [14:0]  i_temp_sample,
    input  wire                i_hum_ok,
    input  wire  [12:0]        i_hum_sample,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic               o_cmd_kind,
    output logic [6:0]         o_cmd_speed,
    output logic               o_cmd_on,
    output logic               o_boost_active,
    output logic signed [14:0] o_temp_filtered,
    output logic [12:0]        o_hum_filtered
);

    // filter scale shift and wide compare width
    localparam int unsigned SH = SAMPLE_FRAC_BITS + 8;
    localparam int unsigned XW = SH + 32;

    // captured transaction
    logic [31:0]        r_now;
    logic               r_mv;
    logic [6:0]         r_speed;
    logic               r_on;
    logic               r_tok;
    logic signed [14:0] r_ts;
    logic               r_hok;
    logic [12:0]        r_hs;

    // persistent state
    logic               r_guard;
    logic               r_primed;
    logic signed [23:0] r_tavg;
    logic signed [23:0] r_havg;
    logic [6:0]         r_base;
    logic               r_base_on;
    logic [6:0]         r_prev;
    logic [31:0]        r_last_tick;
    logic [31:0]        r_above;
    logic [31:0]        r_below;
    logic [31:0]        r_invalid;
    logic [31:0]        r_last_cmd;

    // divider
    logic               r_div_sel;
    logic               r_div_zero;
    logic               r_div_sat;
    logic [14:0]        r_div_rem;
    logic [7:0]         r_div_den;
    logic [6:0]         r_div_q;
    logic [2:0]         r_div_cnt;
    logic [6:0]         r_sev_t;
    logic [6:0]         r_sev_h;

    // pending result and output slot
    logic               r_res_kind;
    logic [6:0]         r_res_speed;
    logic               r_res_on;
    logic               r_res_active;
    logic               r_out_valid;
    logic               r_out_kind;
    logic [6:0]         r_out_speed;
    logic               r_out_on;
    logic               r_out_active;
    logic signed [14:0] r_out_tf;
    logic [12:0]        r_out_hf;

    // effective limits
    logic [7:0] lim_t;
    logic [7:0] lim_h;
    assign lim_t = (i_temp_limit == 8'd0) ? 8'd1 : i_temp_limit;
    assign lim_h = (i_hum_limit == 7'd0) ? 8'd1 : {1'b0, i_hum_limit};

    // gate phase decisions
    logic [31:0] since_tick;
    logic [31:0] since_inv;
    logic        gap_skip;
    logic        early;
    logic        restore_early;
    logic        learn_early;
    logic        no_sensor;
    logic        restore_inv;
    logic        gate_done;
    logic        gate_emit;

    always_comb begin
        since_tick    = r_now - r_last_tick;
        since_inv     = r_now - r_invalid;
        gap_skip      = (r_last_tick != 32'd0) && (since_tick < fbs_pkg::TICK_GAP_MS);
        early         = !i_guard_enable || !r_mv;
        restore_early = early && r_guard && r_mv;
        learn_early   = early && r_mv && !r_guard;
        no_sensor     = !r_tok && !r_hok;
        restore_inv   = !early && no_sensor && r_guard && (r_invalid != 32'd0)
                        && (since_inv >= fbs_pkg::INVALID_MS);
        gate_done     = gap_skip || early || no_sensor;
        gate_emit     = !gap_skip && (restore_early || restore_inv);
    end

    // EMA step: avg + floor(46 * ((s << 8) - avg) / 256)
    logic signed [31:0] ema_t_d;
    logic signed [31:0] ema_t_p;
    logic signed [31:0] ema_t_n;
    logic signed [31:0] ema_h_d;
    logic signed [31:0] ema_h_p;
    logic signed [31:0] ema_h_n;

    always_comb begin
        ema_t_d = ($signed(32'(r_ts)) <<< 8) - $signed(32'(r_tavg));
        ema_t_p = ema_t_d * 32'sd46;
        ema_t_n = $signed(32'(r_tavg)) + (ema_t_p >>> 8);
        ema_h_d = $signed(32'({r_hs, 8'b0})) - $signed(32'(r_havg));
        ema_h_p = ema_h_d * 32'sd46;
        ema_h_n = $signed(32'(r_havg)) + (ema_h_p >>> 8);
    end

    // thresholds and hysteresis levels
    logic signed [XW-1:0] tavg_x;
    logic signed [XW-1:0] havg_x;
    logic signed [XW-1:0] t_thr;
    logic signed [XW-1:0] h_thr;
    logic [15:0]          t_mx;
    logic [15:0]          h_mx;
    logic signed [15:0]   t_k;
    logic signed [15:0]   h_k;
    logic signed [XW-1:0] t_lvl;
    logic signed [XW-1:0] h_lvl;
    logic                 below_t;
    logic                 below_h;
    logic                 exceeded;
    logic                 clear;

    always_comb begin
        tavg_x   = $signed(XW'(r_tavg));
        havg_x   = $signed(XW'(r_havg));
        t_thr    = $signed(XW'(lim_t) << SH);
        h_thr    = $signed(XW'(lim_h) << SH);
        t_mx     = (lim_t > 8'(fbs_pkg::TEMP_CLR_FLOOR)) ? 16'(lim_t) : fbs_pkg::TEMP_CLR_FLOOR;
        h_mx     = (lim_h > 8'(fbs_pkg::HUM_CLR_FLOOR)) ? 16'(lim_h) : fbs_pkg::HUM_CLR_FLOOR;
        t_k      = $signed(16'(16'(lim_t) * 16'd20) - t_mx);
        h_k      = $signed(16'(16'(lim_h) * 16'd20) - h_mx);
        t_lvl    = $signed(XW'(t_k)) <<< SH;
        h_lvl    = $signed(XW'(h_k)) <<< SH;
        below_t  = ((tavg_x <<< 4) + (tavg_x <<< 2)) <= t_lvl;
        below_h  = ((havg_x <<< 4) + (havg_x <<< 2)) <= h_lvl;
        exceeded = (r_tok && (tavg_x >= t_thr)) || (r_hok && (havg_x >= h_thr));
        clear    = (!r_tok || below_t) && (!r_hok || below_h);
    end

    // evaluate phase timers
    logic [31:0] above_eff;
    logic [31:0] below_a;
    logic [31:0] below_eff;
    logic        activate;
    logic        guard_eff;
    logic        clear_elapsed;
    logic        eval_done;
    logic        eval_emit;

    always_comb begin
        if (exceeded) begin
            above_eff = (r_above == 32'd0) ? r_now : r_above;
        end else begin
            above_eff = 32'd0;
        end
        below_a       = exceeded ? 32'd0 : r_below;
        below_eff     = (below_a == 32'd0) ? r_now : below_a;
        activate      = !r_guard && (above_eff != 32'd0)
                        && ((r_now - above_eff) >= fbs_pkg::ACTIVATE_MS);
        guard_eff     = r_guard || activate;
        clear_elapsed = (below_eff != 32'd0) && ((r_now - below_eff) >= fbs_pkg::CLEAR_MS);
        eval_done     = !guard_eff || clear;
        eval_emit     = guard_eff && clear && clear_elapsed;
    end

    // divider setup: severity = floor(((avg - L*U) * 100 / U) / L)
    logic signed [XW-1:0] dv_avg;
    logic signed [XW-1:0] dv_thr;
    logic [7:0]           dv_lim;
    logic signed [XW-1:0] dv_diff;
    logic signed [XW-1:0] dv_x100;
    logic signed [XW-1:0] dv_dd;
    logic [14:0]          dv_cap;
    logic [14:0]          dv_trial;
    logic [14:0]          dv_rem_n;
    logic [6:0]           dv_q_n;
    logic [6:0]           dv_sev;

    always_comb begin
        dv_avg   = (i_cmd.div_sel == fbs_pkg::SEL_HUM) ? havg_x : tavg_x;
        dv_thr   = (i_cmd.div_sel == fbs_pkg::SEL_HUM) ? h_thr : t_thr;
        dv_lim   = (i_cmd.div_sel == fbs_pkg::SEL_HUM) ? lim_h : lim_t;
        dv_diff  = dv_avg - dv_thr;
        dv_x100  = (dv_diff <<< 6) + (dv_diff <<< 5) + (dv_diff <<< 2);
        dv_dd    = dv_x100 >>> SH;
        dv_cap   = 15'(dv_lim) * 15'd100;
        // one restoring step
        dv_trial = 15'(r_div_den) << r_div_cnt;
        dv_rem_n = r_div_rem;
        dv_q_n   = r_div_q;
        if (r_div_rem >= dv_trial) begin
            dv_rem_n           = r_div_rem - dv_trial;
            dv_q_n[r_div_cnt]  = 1'b1;
        end
        if (r_div_zero) begin
            dv_sev = 7'd0;
        end else if (r_div_sat) begin
            dv_sev = 7'(fbs_pkg::SPEED_MAX);
        end else begin
            dv_sev = dv_q_n;
        end
    end

    // decide phase: shape boost speed
    logic [6:0] sev;
    logic [7:0] want_sum;
    logic [7:0] want_a;
    logic [7:0] want_b;
    logic [7:0] want_c;
    logic [7:0] ramp_top;
    logic [7:0] target;
    logic [7:0] spd8;
    logic [7:0] diff;
    logic       dec_emit;

    always_comb begin
        sev      = (r_sev_h > r_sev_t) ? r_sev_h : r_sev_t;
        spd8     = 8'(r_speed);
        want_sum = 8'(r_base) + fbs_pkg::BOOST_OFFSET + 8'(sev);
        want_a   = (want_sum > fbs_pkg::SPEED_MAX) ? fbs_pkg::SPEED_MAX : want_sum;
        want_b   = (want_a < 8'(r_base)) ? 8'(r_base) : want_a;
        want_c   = (want_b < spd8) ? spd8 : want_b;
        ramp_top = 8'(r_prev) + fbs_pkg::RAMP_STEP;
        target   = want_c;
        if (r_prev != 7'd0 && target > ramp_top) target = ramp_top;
        if (target > fbs_pkg::SPEED_MAX) target = fbs_pkg::SPEED_MAX;
        diff     = (target >= spd8) ? (target - spd8) : (spd8 - target);
        dec_emit = !((diff < 8'd2) && r_on)
                   && !((r_last_cmd != 32'd0)
                        && ((r_now - r_last_cmd) < fbs_pkg::CMD_GAP_MS));
    end

    // restore request in this cycle
    logic do_restore;
    assign do_restore = (i_cmd.gate && gate_emit) || (i_cmd.eval && eval_emit);

    // status
    always_comb begin
        o_stat          = '0;
        o_stat.done     = (i_cmd.gate && gate_done) || (i_cmd.eval && eval_done);
        o_stat.emit     = (i_cmd.gate && gate_emit) || (i_cmd.eval && eval_emit)
                          || (i_cmd.decide && dec_emit);
        o_stat.div_last = (r_div_cnt == 3'd0);
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    // capture transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now   <= i_now_ms;
            r_mv    <= i_fan_valid;
            r_speed <= (i_fan_speed > 7'(fbs_pkg::SPEED_MAX)) ? 7'(fbs_pkg::SPEED_MAX)
                                                              : i_fan_speed;
            r_on    <= i_fan_on;
            r_tok   <= i_temp_ok;
            r_ts    <= i_temp_sample;
            r_hok   <= i_hum_ok;
            r_hs    <= i_hum_sample;
        end
    end

    // safeguard state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard     <= 1'b0;
            r_primed    <= 1'b0;
            r_tavg      <= '0;
            r_havg      <= '0;
            r_base      <= '0;
            r_base_on   <= 1'b0;
            r_prev      <= '0;
            r_last_tick <= '0;
            r_above     <= '0;
            r_below     <= '0;
            r_invalid   <= '0;
            r_last_cmd  <= '0;
        end else begin
            // gate: stamp tick, learn base, clear timers when disabled, track invalid sensor time
            if (i_cmd.gate && !gap_skip) begin
                r_last_tick <= r_now;
                if (learn_early) begin
                    r_base    <= r_speed;
                    r_base_on <= r_on;
                    r_prev    <= r_speed;
                end
                if (early && !i_guard_enable) begin
                    r_above <= '0;
                    r_below <= '0;
                end
                if (!early && no_sensor && r_invalid == 32'd0) r_invalid <= r_now;
                if (!early && !no_sensor) r_invalid <= '0;
            end
            // filter: prime or advance, learn base while idle
            if (i_cmd.filt) begin
                if (!r_primed) begin
                    r_tavg   <= r_tok ? ($signed(24'(r_ts)) <<< 8) : 24'sd0;
                    r_havg   <= r_hok ? $signed(24'({r_hs, 8'b0})) : 24'sd0;
                    r_primed <= 1'b1;
                end else begin
                    if (r_tok) r_tavg <= ema_t_n[23:0];
                    if (r_hok) r_havg <= ema_h_n[23:0];
                end
                if (!r_guard) begin
                    r_base    <= r_speed;
                    r_base_on <= r_on;
                    r_prev    <= r_speed;
                end
            end
            // evaluate: hold timers and activation
            if (i_cmd.eval) begin
                r_above <= above_eff;
                r_guard <= guard_eff;
                if (activate) r_last_cmd <= '0;
                if (guard_eff) begin
                    r_below <= clear ? below_eff : 32'd0;
                end else begin
                    r_below <= below_a;
                end
            end
            // decide: record boost transaction
            if (i_cmd.decide && dec_emit) begin
                r_last_cmd <= r_now;
                r_prev     <= target[6:0];
            end
            // restore: drop everything but the filters
            if (do_restore) begin
                r_guard     <= 1'b0;
                r_base_on   <= 1'b0;
                r_base      <= '0;
                r_prev      <= '0;
                r_last_tick <= '0;
                r_above     <= '0;
                r_below     <= '0;
                r_invalid   <= '0;
                r_last_cmd  <= '0;
            end
        end
    end

    // severity divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= 3'(fbs_pkg::DIV_BITS - 1);
        end else if (i_cmd.div_step && r_div_cnt != 3'd0) begin
            r_div_cnt <= r_div_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_sel  <= i_cmd.div_sel;
            r_div_zero <= dv_avg < dv_thr;
            r_div_sat  <= dv_dd >= $signed(XW'(dv_cap));
            r_div_rem  <= dv_dd[14:0];
            r_div_den  <= dv_lim;
            r_div_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= dv_rem_n;
            r_div_q   <= dv_q_n;
            if (r_div_cnt == 3'd0) begin
                if (r_div_sel == fbs_pkg::SEL_HUM) begin
                    r_sev_h <= dv_sev;
                end else begin
                    r_sev_t <= dv_sev;
                end
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (do_restore) begin
            r_res_kind   <= fbs_pkg::KIND_RESTORE;
            r_res_speed  <= r_base;
            r_res_on     <= r_base_on;
            r_res_active <= 1'b0;
        end else if (i_cmd.decide && dec_emit) begin
            r_res_kind   <= fbs_pkg::KIND_BOOST;
            r_res_speed  <= target[6:0];
            r_res_on     <= 1'b1;
            r_res_active <= 1'b1;
        end
    end

    // rounded filter values
    logic signed [24:0] t_round;
    logic signed [24:0] h_round;
    always_comb begin
        t_round = ($signed(25'(r_tavg)) + 25'sd128) >>> 8;
        h_round = ($signed(25'(r_havg)) + 25'sd128) >>> 8;
    end

    // output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind   <= r_res_kind;
            r_out_speed  <= r_res_speed;
            r_out_on     <= r_res_on;
            r_out_active <= r_res_active;
            r_out_tf     <= t_round[14:0];
            r_out_hf     <= h_round[12:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cmd_kind      = r_out_kind;
    assign o_cmd_speed     = r_out_speed;
    assign o_cmd_on        = r_out_on;
    assign o_boost_active  = r_out_active;
    assign o_temp_filtered = r_out_tf;
    assign o_hum_filtered  = r_out_hf;

`ifndef SYNTHESIS
    // a boost transaction always enables the fans with the safeguard active
    a_boost_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cmd_kind == fbs_pkg::KIND_BOOST) |-> (o_cmd_on && o_boost_active))
        else $error("fbs_dp: boost result with bad enable or active flag");

    // a restore transaction leaves the safeguard inactive
    a_restore_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cmd_kind == fbs_pkg::KIND_RESTORE) |-> !o_boost_active)
        else $error("fbs_dp: restore result flagged active");

    // commanded speed stays in range
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cmd_speed <= 7'd100))
        else $error("fbs_dp: commanded speed above full scale");
`endif

endmodule

`default_nettype wire

FILE: sv/fan_boost_safeguard.sv
// fan_boost_safeguard: duct temperature and humidity safeguard for an extraction fan group.
// Top level: configuration registers, controller fbs_ctrl and datapath fbs_dp.
// Depends on fbs_pkg, fbs_ctrl, fbs_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one service tick per transaction:
//   timestamp, fan group state and duct samples. Output channel (o_out_valid /
//   i_out_stall) carries at most one fan command per tick: boost or restore-to-base,
//   plus the filtered duct values.
//   A tick ends at the gate phase, at the evaluate phase, or after the severity
//   division (two 7-bit restoring divisions, one quotient bit per cycle, each after
//   its own setup state); a tick that emits a command then passes through the emit
//   state into the output register. One tick is in work at a time; o_in_stall stays
//   high until it finishes.
//   The output register holds a command while i_out_stall is high; the next tick is
//   still accepted and runs until it has a command of its own to hand over.
//   Reset (synchronous, active low) clears the safeguard state, filters and timers and
//   loads the register defaults: safeguard off, 60 C, 80 %rh.
//   Registers (APB, 4-byte stride): 0 guard_enable, 1 temp_limit, 2 hum_limit. Write
//   them only while no tick is in work.
`timescale 1ns / 1ps
`default_nettype none

module fan_boost_safeguard #(
    parameter int unsigned SAMPLE_FRAC_BITS = 6
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // tick input
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [31:0]        i_now_ms,
    input  wire                i_fan_valid,
    input  wire  [6:0]         i_fan_speed,
    input  wire                i_fan_on,
    input  wire                i_temp_ok,
    input  wire signed [14:0]  i_temp_sample,
    input  wire                i_hum_ok,
    input  wire  [12:0]        i_hum_sample,
    // command output
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic               o_cmd_kind,
    output logic [6:0]         o_cmd_speed,
    output logic               o_cmd_on,
    output logic               o_boost_active,
    output logic signed [14:0] o_temp_filtered,
    output logic [12:0]        o_hum_filtered
);

    logic       r_guard_enable;
    logic [7:0] r_temp_limit;
    logic [6:0] r_hum_limit;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_enable <= fbs_pkg::GUARD_ENABLE_RST;
            r_temp_limit   <= fbs_pkg::TEMP_LIMIT_RST;
            r_hum_limit    <= fbs_pkg::HUM_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fbs_pkg::REG_GUARD_ENABLE: r_guard_enable <= pwdata[0];
                fbs_pkg::REG_TEMP_LIMIT:   r_temp_limit   <= pwdata[7:0];
                fbs_pkg::REG_HUM_LIMIT:    r_hum_limit    <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            fbs_pkg::REG_GUARD_ENABLE: prdata = 32'(r_guard_enable);
            fbs_pkg::REG_TEMP_LIMIT:   prdata = 32'(r_temp_limit);
            fbs_pkg::REG_HUM_LIMIT:    prdata = 32'(r_hum_limit);
            default:                   prdata = 32'd0;
        endcase
    end

    fbs_pkg::t_dp_cmd  cmd;
    fbs_pkg::t_dp_stat stat;

    fbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fbs_dp #(
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_guard_enable  (r_guard_enable),
        .i_temp_limit    (r_temp_limit),
        .i_hum_limit     (r_hum_limit),
        .i_now_ms        (i_now_ms),
        .i_fan_valid     (i_fan_valid),
        .i_fan_speed     (i_fan_speed),
        .i_fan_on        (i_fan_on),
        .i_temp_ok       (i_temp_ok),
        .i_temp_sample   (i_temp_sample),
        .i_hum_ok        (i_hum_ok),
        .i_hum_sample    (i_hum_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cmd_kind      (o_cmd_kind),
        .o_cmd_speed     (o_cmd_speed),
        .o_cmd_on        (o_cmd_on),
        .o_boost_active  (o_boost_active),
        .o_temp_filtered (o_temp_filtered),
        .o_hum_filtered  (o_hum_filtered)
    );

endmodule

`default_nettype wire
